>>> hdl/wcd_pkg.sv
// Shared types and constants of the warped cycle delay.
`default_nettype none

package wcd_pkg;

  localparam int SampleW = 24;
  localparam int CfgW    = 17;
  localparam int DegW    = 4;
  localparam int MixW    = 17;
  localparam int IdxW    = 2;

  // configuration register indexes
  typedef enum logic [IdxW-1:0] {
    CFG_CYCLE_LENGTH = 2'd0,
    CFG_WARP_DEGREE  = 2'd1,
    CFG_WARP_MIX     = 2'd2
  } cfg_idx_e;

  localparam logic [CfgW-1:0] LenReset = 17'd4800;
  localparam logic [DegW-1:0] DegReset = 4'd2;
  localparam logic [MixW-1:0] MixReset = 17'd0;
  localparam logic [MixW-1:0] MixOne   = 17'h10000;
  localparam logic [DegW-1:0] DegMax   = 4'd8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_DIV,
    ST_POW,
    ST_SCALE,
    ST_MSTART,
    ST_MIX,
    ST_RDA,
    ST_RDB,
    ST_RDW,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> hdl/wcd_store.sv
// Sample store: single-port memory with a zeroing sweep after reset.
`default_nettype none

module wcd_store import wcd_pkg::*; #(
  parameter int Depth = 65536,
  parameter int AddrW = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               we_i,
  input  wire logic [AddrW-1:0]   addr_i,
  input  wire logic [SampleW-1:0] wdata_i,
  output logic      [SampleW-1:0] rdata_o,
  output logic                    clearing_o
);

  logic [SampleW-1:0] mem [Depth];
  logic [SampleW-1:0] rdata_q;
  logic [AddrW-1:0]   clr_cnt_q;
  logic               clearing_q;

  // write, zero or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  // advance the zeroing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

`default_nettype wire

>>> hdl/wcd_div.sv
// Bit-serial restoring divider for the normalised cycle position.
`default_nettype none

module wcd_div #(
  parameter int NumW  = 17,
  parameter int FracW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [NumW-1:0]  den_i,
  output logic      [FracW-1:0] quot_o,
  output logic                  done_o
);

  localparam int CntW = $clog2(FracW + 1);

  logic [NumW-1:0]  rem_q;
  logic [FracW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [NumW:0]    rem2;
  logic             ge;

  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, den_i};

  // one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(FracW);
        rem_q  <= num_i;
        quot_q <= '0;
      end else if (busy_q) begin
        rem_q  <= ge ? NumW'(rem2 - {1'b0, den_i}) : NumW'(rem2);
        quot_q <= {quot_q[FracW-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> hdl/wcd_mac.sv
// Bit-serial blend: lag = (t1*mix + t2*(1-mix)) >> 16, one mix bit per cycle.
`default_nettype none

module wcd_mac import wcd_pkg::*; #(
  parameter int TW = 33
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [TW-1:0]   t1_i,
  input  wire logic [TW-1:0]   t2_i,
  input  wire logic [MixW-1:0] mix_i,
  output logic      [TW-1:0]   lag_o,
  output logic                 done_o
);

  localparam int AccW = TW + MixW + 1;
  localparam int CntW = $clog2(MixW + 1);

  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] dsh_q;
  logic        [MixW-1:0] mix_q;
  logic        [CntW-1:0] cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic signed [TW:0]     diff;

  assign diff = $signed({1'b0, t1_i}) - $signed({1'b0, t2_i});

  // start from t2 at full weight, add (t1 - t2) times each set mix bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      dsh_q  <= '0;
      mix_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(MixW);
        acc_q  <= $signed(AccW'(t2_i) << (MixW - 1));
        dsh_q  <= AccW'(diff);
        mix_q  <= mix_i;
      end else if (busy_q) begin
        if (mix_q[0]) begin
          acc_q <= acc_q + dsh_q;
        end
        dsh_q <= dsh_q <<< 1;
        mix_q <= mix_q >> 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign lag_o  = acc_q[MixW-1 +: TW];
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> hdl/warped_cycle_delay.sv
// Top level of the warped cycle delay: control sequencer, registers and datapath.
//
// Each sample is written into a circular store whose length is the configured
// cycle length, and a sample is read back at a lagged position that follows a
// power curve of the position within the cycle. The lagged position is blended
// with the plain position by warp_mix, and the result is linearly interpolated
// between two neighbouring entries. A transaction passes through the bit-serial
// divider, the power loop (one multiply per cycle), the bit-serial blend, three
// accesses to the single-port store and the hand-off and set-up states. After
// reset the store is zeroed by a sweep, during which no sample is taken;
// configuration writes are accepted at any time but must only be made while the
// block is idle.
`default_nettype none

module warped_cycle_delay import wcd_pkg::*; #(
  parameter int MAX_CYCLE = 65536,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [SampleW-1:0] sample_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [SampleW-1:0] sample_out_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [IdxW-1:0]    cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  localparam int AW = $clog2(MAX_CYCLE);
  localparam int LW = AW + 1;
  localparam int F  = FRAC_BITS;
  localparam int TW = AW + F + 1;
  localparam int PW = SampleW + F + 2;
  localparam int SW = SampleW + 2;

  state_e state_q, state_d;

  logic [CfgW-1:0]    cfg_len_q;
  logic [DegW-1:0]    cfg_deg_q;
  logic [MixW-1:0]    cfg_mix_q;
  logic [LW-1:0]      len_c;
  logic [DegW-1:0]    deg_c;
  logic [MixW-1:0]    mix_c;

  logic [AW-1:0]      wp_q;
  logic [AW-1:0]      cur_pos_q;
  logic [SampleW-1:0] sample_q;
  logic [F-1:0]       x_q;
  logic [F-1:0]       y_q;
  logic [2:0]         pow_cnt_q;
  logic [TW-1:0]      t1_q;
  logic [AW-1:0]      ipos_q;
  logic [AW-1:0]      nxt_q;
  logic [F-1:0]       frac_q;
  logic [SampleW-1:0] a_q;
  logic signed [PW-1:0] prod_q;
  logic [SampleW-1:0] out_q;
  logic               out_valid_q;

  logic               accept;
  logic [LW-1:0]      adj_pos;
  logic [LW-1:0]      next_pos;
  logic               div_start, div_done;
  logic [F-1:0]       quot;
  logic               mac_start, mac_done;
  logic [TW-1:0]      lag;
  logic [LW-1:0]      ipos_raw, ipos_c, nxt_c;
  logic [2*F-1:0]     pow_prod;
  logic               st_we;
  logic [AW-1:0]      st_addr;
  logic [SampleW-1:0] st_rdata;
  logic               clearing;
  logic signed [SampleW:0] diff;
  logic signed [PW-1:0]    prod_sh;
  logic signed [SW-1:0]    sum;
  logic [SampleW-1:0]      sat;
  logic                    load_out;

  // clamp the configuration to its working ranges
  always_comb begin
    if (32'(cfg_len_q) > 32'(MAX_CYCLE)) begin
      len_c = LW'(MAX_CYCLE);
    end else if (cfg_len_q < 17'd2) begin
      len_c = LW'(2);
    end else begin
      len_c = LW'(cfg_len_q);
    end
    if (cfg_deg_q == '0) begin
      deg_c = 4'd1;
    end else if (cfg_deg_q > DegMax) begin
      deg_c = DegMax;
    end else begin
      deg_c = cfg_deg_q;
    end
    mix_c = (cfg_mix_q > MixOne) ? MixOne : cfg_mix_q;
  end

  // take configuration transactions
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LenReset;
      cfg_deg_q <= DegReset;
      cfg_mix_q <= MixReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CYCLE_LENGTH: cfg_len_q <= cfg_data_i;
        CFG_WARP_DEGREE:  cfg_deg_q <= cfg_data_i[DegW-1:0];
        CFG_WARP_MIX:     cfg_mix_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // write position, wrapped into a possibly shortened cycle
  assign adj_pos  = ({1'b0, wp_q} >= len_c) ? '0 : {1'b0, wp_q};
  assign next_pos = ((adj_pos + 1'b1) >= len_c) ? '0 : adj_pos + 1'b1;
  assign accept   = in_valid_i && in_ready_o;

  // lagged read index and its neighbour
  assign ipos_raw = lag[F +: LW];
  assign ipos_c   = (ipos_raw >= len_c) ? len_c - 1'b1 : ipos_raw;
  assign nxt_c    = ((ipos_c + 1'b1) >= len_c) ? '0 : ipos_c + 1'b1;

  assign pow_prod = y_q * x_q;

  // interpolation: a + floor((b - a) * frac / 2^F), then saturate
  assign diff    = $signed({st_rdata[SampleW-1], st_rdata}) - $signed({a_q[SampleW-1], a_q});
  assign prod_sh = prod_q >>> F;
  assign sum     = $signed({{2{a_q[SampleW-1]}}, a_q}) + prod_sh[SW-1:0];

  always_comb begin
    if (sum > $signed(SW'(24'sh7FFFFF))) begin
      sat = 24'h7FFFFF;
    end else if (sum < -$signed(SW'(24'h800000))) begin
      sat = 24'h800000;
    end else begin
      sat = sum[SampleW-1:0];
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and control
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    mac_start  = 1'b0;
    st_we      = 1'b0;
    st_addr    = ipos_q;
    load_out   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (!clearing) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        st_we     = 1'b1;
        st_addr   = cur_pos_q;
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_POW;
      end
      ST_POW: begin
        if (pow_cnt_q == '0) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        state_d = ST_MSTART;
      end
      ST_MSTART: begin
        mac_start = 1'b1;
        state_d   = ST_MIX;
      end
      ST_MIX: begin
        if (mac_done) state_d = ST_RDA;
      end
      ST_RDA: begin
        st_addr = ipos_q;
        state_d = ST_RDB;
      end
      ST_RDB: begin
        st_addr = nxt_q;
        state_d = ST_RDW;
      end
      ST_RDW: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q  <= sample_in_i;
      cur_pos_q <= adj_pos[AW-1:0];
    end
    if (state_q == ST_DIV && div_done) begin
      x_q       <= quot;
      y_q       <= quot;
      pow_cnt_q <= 3'(deg_c - 4'd1);
    end
    if (state_q == ST_POW && pow_cnt_q != '0) begin
      y_q       <= pow_prod[F +: F];
      pow_cnt_q <= pow_cnt_q - 1'b1;
    end
    if (state_q == ST_SCALE) begin
      t1_q <= TW'(len_c * y_q);
    end
    if (state_q == ST_MIX && mac_done) begin
      ipos_q <= ipos_c[AW-1:0];
      nxt_q  <= nxt_c[AW-1:0];
      frac_q <= lag[F-1:0];
    end
    if (state_q == ST_RDB) begin
      a_q <= st_rdata;
    end
    if (state_q == ST_RDW) begin
      prod_q <= diff * $signed({1'b0, frac_q});
    end
    if (load_out) begin
      out_q <= sat;
    end
  end

  // hold the write position and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wp_q <= next_pos[AW-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  wcd_div #(
    .NumW  (LW),
    .FracW (F)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({1'b0, cur_pos_q}),
    .den_i   (len_c),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  wcd_mac #(
    .TW (TW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .t1_i    (t1_q),
    .t2_i    (TW'({cur_pos_q, F'(0)})),
    .mix_i   (mix_c),
    .lag_o   (lag),
    .done_o  (mac_done)
  );

  wcd_store #(
    .Depth (MAX_CYCLE),
    .AddrW (AW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (st_we),
    .addr_i     (st_addr),
    .wdata_i    (sample_q),
    .rdata_o    (st_rdata),
    .clearing_o (clearing)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench of the warped cycle delay with a scoreboard class.
`default_nettype none

module testbench import wcd_pkg::*; ();

  localparam int StoreDepth = 65536;
  localparam int FracW      = 16;
  localparam int CycleLimit = 2000000;

  // predicts each output sample from its own copy of store, position and registers
  class lag_scoreboard;
    logic [SampleW-1:0] store [StoreDepth];
    longint unsigned    wpos;
    logic [CfgW-1:0]    len_reg;
    logic [DegW-1:0]    deg_reg;
    logic [MixW-1:0]    mix_reg;
    logic [SampleW-1:0] expected_q [$];
    int                 errors;

    function new();
      foreach (store[i]) store[i] = '0;
      wpos    = 0;
      len_reg = LenReset;
      deg_reg = DegReset;
      mix_reg = MixReset;
      errors  = 0;
    endfunction

    function void configure(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_CYCLE_LENGTH: len_reg = value;
        CFG_WARP_DEGREE:  deg_reg = value[DegW-1:0];
        CFG_WARP_MIX:     mix_reg = value;
        default: ;
      endcase
    endfunction

    // store the sample and queue the interpolated read at the lagged position
    function void note_sample(logic [SampleW-1:0] smp);
      longint unsigned len, mix, x, y, lag, ipos, nxt, frac, p;
      int unsigned     deg;
      longint          a, b, acc, r;
      len = 64'(len_reg);
      deg = 32'(deg_reg);
      mix = 64'(mix_reg);
      if (len < 2) len = 2;
      if (len > StoreDepth) len = StoreDepth;
      if (deg < 1) deg = 1;
      if (deg > DegMax) deg = 32'(DegMax);
      if (mix > MixOne) mix = 64'(MixOne);
      if (wpos >= len) wpos = 0;
      p = wpos;
      store[p] = smp;
      x = (p << FracW) / len;
      y = x;
      for (int k = 1; k < deg; k++) y = (y * x) >> FracW;
      lag  = (len * y * mix + (p << FracW) * (65536 - mix)) >> 16;
      ipos = lag >> FracW;
      frac = lag & ((64'd1 << FracW) - 1);
      if (ipos >= len) ipos = len - 1;
      nxt = ipos + 1;
      if (nxt >= len) nxt = 0;
      a   = longint'($signed(store[ipos]));
      b   = longint'($signed(store[nxt]));
      acc = a * longint'((64'd1 << FracW) - frac) + b * longint'(frac);
      r   = acc >>> FracW;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      expected_q.push_back(r[SampleW-1:0]);
      p++;
      if (p >= len) p = 0;
      wpos = p;
    endfunction

    function void check_sample(logic [SampleW-1:0] actual);
      logic [SampleW-1:0] want;
      if (expected_q.size() == 0) begin
        $error("sample_out: unexpected transaction, actual %0d", $signed(actual));
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (want !== actual) begin
          $error("sample_out: expected %0d actual %0d", $signed(want), $signed(actual));
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [SampleW-1:0] sample_out_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [IdxW-1:0]    cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;

  lag_scoreboard sb = new();
  bit            quiet_run;
  bit            hold_request;
  int unsigned   cycle_count;

  warped_cycle_delay uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .sample_in_i,
    .out_valid_o, .out_ready_i, .sample_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // end the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: check results, stall in bursts, hold off long on request
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_sample(sample_out_o);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = 600;
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // offer one sample and hold it until taken, then idle at random
  task automatic send_sample(logic [SampleW-1:0] smp);
    in_valid_i  <= 1'b1;
    sample_in_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(smp);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.configure(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [CfgW-1:0] len, logic [CfgW-1:0] deg, logic [CfgW-1:0] mix);
    drain();
    write_reg(CFG_CYCLE_LENGTH, len);
    write_reg(CFG_WARP_DEGREE, deg);
    write_reg(CFG_WARP_MIX, mix);
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      default: return SampleW'($urandom());
    endcase
  endfunction

  initial begin
    logic [CfgW-1:0] len, deg, mix;
    quiet_run    = 1'b0;
    hold_request = 1'b0;
    cycle_count  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes at reset settings, then clamped and edge settings
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    set_config(17'd2, 17'd0, 17'h10000);
    repeat (4) send_sample(rand_sample());
    set_config(17'd1, 17'd15, 17'h1FFFF);
    repeat (4) send_sample(rand_sample());
    set_config(17'h1FFFF, 17'd8, 17'h08000);
    repeat (4) send_sample(rand_sample());
    // shortened cycle while the position lies beyond it
    set_config(17'd3, 17'd3, 17'h0C000);
    repeat (6) send_sample(rand_sample());

    // random phases, often short cycles so the store wraps often
    for (int ph = 0; ph < 13; ph++) begin
      case ($urandom_range(0, 3))
        0:       len = CfgW'($urandom());
        1:       len = 17'h10000;
        default: len = CfgW'($urandom_range(2, 40));
      endcase
      deg = CfgW'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0:       mix = 17'd0;
        1:       mix = 17'h10000;
        default: mix = CfgW'($urandom());
      endcase
      if (ph == 12) quiet_run = 1'b1;
      set_config(len, deg, mix);
      // fill the block while the receiver holds off
      if (ph == 5) hold_request = 1'b1;
      repeat (148) send_sample(rand_sample());
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
